@@ src/phd_pkg.sv @@
// ----------------------------------------------------------------------------
// phd_pkg
// Types and constants shared by the packet header deframer modules.
// ----------------------------------------------------------------------------
package phd_pkg;

    localparam int HDR_BYTES     = 23;
    localparam int POS_TYPE      = 4;
    localparam int POS_CHANNEL   = 6;
    localparam int POS_SENDER    = 7;
    localparam int POS_SEQUENCE  = 11;
    localparam int POS_TIME      = 15;
    localparam int POS_LENGTH    = 19;

    localparam logic [31:0] MAGIC_RESET   = 32'h5350_524B;
    localparam logic [16:0] PAYLOAD_RESET = 17'(64 * 1024);

    localparam logic CFG_MAGIC       = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
    localparam logic [2:0] ST_BEYOND    = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE = 3'd4;

    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = 3;
    localparam int FILL_W      = 4;
    localparam int STALL_LEVEL = FIFO_DEPTH - 4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [15:0] msg_type;
        logic [7:0]  channel_id;
        logic [31:0] sender_id;
        logic [31:0] sequence_num;
        logic [31:0] timestamp_bits;
        logic [31:0] payload_length;
        logic        run_last;
    } t_result;

    typedef struct packed {
        logic    pay_vld;
        logic    sum_vld;
        t_result pay;
        t_result sum;
    } t_push;

endpackage

@@ src/packet_header_deframer.sv @@
// ----------------------------------------------------------------------------
// packet_header_deframer
// Gathers a 23-byte little-endian packet header, passes payload bytes on and
// reports a summary with a status at the end of each packet.
// ----------------------------------------------------------------------------
// One packet byte is accepted per clock cycle while o_in_stall is low; each
// byte is held in the input register and passes through the parser, and its
// results are written into an eight-entry result queue whose head is offered
// on the output. A final byte that is also a payload byte yields two results,
// and since the queue drains one result per cycle while the output is not
// stalled, the input is stalled whenever the queue fill plus the two results
// reserved for the byte in flight would exceed four entries. Configuration is
// written through a plain write port, index zero for the expected magic word
// and index one for the payload limit.
module packet_header_deframer #(
    parameter int MAX_PACKET_BYTES = 131072
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_in,
    input  logic        i_packet_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [2:0]  o_status,
    output logic [15:0] o_msg_type,
    output logic [7:0]  o_channel_id,
    output logic [31:0] o_sender_id,
    output logic [31:0] o_sequence_num,
    output logic [31:0] o_timestamp_bits,
    output logic [31:0] o_payload_length,
    output logic        o_run_last
);

    logic                           in_accept;
    logic                           busy;
    phd_pkg::t_push                 push;
    phd_pkg::t_result               head;
    logic [phd_pkg::FILL_W-1:0]     fill;
    logic [phd_pkg::FILL_W:0]       level;
    logic                           pop;

    assign level      = {1'b0, fill} + {(phd_pkg::FILL_W - 1)'(0), busy, 1'b0};
    assign o_in_stall = (level > (phd_pkg::FILL_W + 1)'(phd_pkg::STALL_LEVEL));
    assign in_accept  = i_in_valid && !o_in_stall;
    assign pop        = o_out_valid && !i_out_stall;

    phd_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_accept  (in_accept),
        .i_data_in    (i_data_in),
        .i_packet_end (i_packet_end),
        .o_busy       (busy),
        .o_push       (push)
    );

    phd_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (o_out_valid),
        .o_head  (head),
        .o_fill  (fill)
    );

    assign o_kind           = head.kind;
    assign o_payload_byte   = head.payload_byte;
    assign o_status         = head.status;
    assign o_msg_type       = head.msg_type;
    assign o_channel_id     = head.channel_id;
    assign o_sender_id      = head.sender_id;
    assign o_sequence_num   = head.sequence_num;
    assign o_timestamp_bits = head.timestamp_bits;
    assign o_payload_length = head.payload_length;
    assign o_run_last       = head.run_last;

endmodule

@@ src/phd_parser.sv @@
// ----------------------------------------------------------------------------
// phd_parser
// Input register, header capture and result formation for one accepted byte per cycle.
// ----------------------------------------------------------------------------
module phd_parser #(
    parameter int MAX_PACKET_BYTES = 131072
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_in_accept,
    input  logic [7:0]        i_data_in,
    input  logic              i_packet_end,
    output logic              o_busy,
    output phd_pkg::t_push    o_push
);

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_BYTES);
    localparam logic [CNT_W-1:0] HDR_CNT = CNT_W'(phd_pkg::HDR_BYTES);

    logic              r_in_valid;
    logic [7:0]        r_data;
    logic              r_end;
    logic [31:0]       r_exp_magic;
    logic [16:0]       r_max_payload;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [31:0]       r_magic, n_magic;
    logic [15:0]       r_type, n_type;
    logic [7:0]        r_channel, n_channel;
    logic [31:0]       r_sender, n_sender;
    logic [31:0]       r_sequence, n_sequence;
    logic [31:0]       r_time, n_time;
    logic [31:0]       r_length, n_length;
    logic [2:0]        status;
    phd_pkg::t_push    push;

    always_comb begin
        n_count    = r_count;
        n_magic    = r_magic;
        n_type     = r_type;
        n_channel  = r_channel;
        n_sender   = r_sender;
        n_sequence = r_sequence;
        n_time     = r_time;
        n_length   = r_length;
        status     = phd_pkg::ST_OK;
        push       = '0;
        push.pay.kind         = phd_pkg::KIND_PAYLOAD;
        push.pay.payload_byte = r_data;
        push.sum.kind         = phd_pkg::KIND_SUMMARY;
        push.sum.run_last     = 1'b1;

        if (r_in_valid && (r_count < MAX_CNT)) begin
            priority if (r_count < CNT_W'(phd_pkg::POS_TYPE)) begin
                n_magic = {r_data, r_magic[31:8]};
            end else if (r_count < CNT_W'(phd_pkg::POS_CHANNEL)) begin
                n_type = {r_data, r_type[15:8]};
            end else if (r_count < CNT_W'(phd_pkg::POS_SENDER)) begin
                n_channel = r_data;
            end else if (r_count < CNT_W'(phd_pkg::POS_SEQUENCE)) begin
                n_sender = {r_data, r_sender[31:8]};
            end else if (r_count < CNT_W'(phd_pkg::POS_TIME)) begin
                n_sequence = {r_data, r_sequence[31:8]};
            end else if (r_count < CNT_W'(phd_pkg::POS_LENGTH)) begin
                n_time = {r_data, r_time[31:8]};
            end else if (r_count < HDR_CNT) begin
                n_length = {r_data, r_length[31:8]};
            end else begin
                push.pay_vld = (32'(r_count - HDR_CNT) < r_length);
            end
            n_count = r_count + CNT_W'(1);
        end

        if (r_in_valid && r_end) begin
            priority if (n_count < HDR_CNT) begin
                status = phd_pkg::ST_SHORT;
            end else if (n_magic != r_exp_magic) begin
                status = phd_pkg::ST_BAD_MAGIC;
            end else if (n_length > 32'(n_count - HDR_CNT)) begin
                status = phd_pkg::ST_BEYOND;
            end else if (n_length > 32'(r_max_payload)) begin
                status = phd_pkg::ST_TOO_LARGE;
            end else begin
                status = phd_pkg::ST_OK;
            end
            push.sum_vld    = 1'b1;
            push.sum.status = status;
            if (status != phd_pkg::ST_SHORT && status != phd_pkg::ST_BAD_MAGIC) begin
                push.sum.msg_type       = n_type;
                push.sum.channel_id     = n_channel;
                push.sum.sender_id      = n_sender;
                push.sum.sequence_num   = n_sequence;
                push.sum.timestamp_bits = n_time;
                push.sum.payload_length = n_length;
            end
            n_count    = '0;
            n_magic    = '0;
            n_type     = '0;
            n_channel  = '0;
            n_sender   = '0;
            n_sequence = '0;
            n_time     = '0;
            n_length   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_exp_magic   <= phd_pkg::MAGIC_RESET;
            r_max_payload <= phd_pkg::PAYLOAD_RESET;
            r_count       <= '0;
            r_magic       <= '0;
            r_type        <= '0;
            r_channel     <= '0;
            r_sender      <= '0;
            r_sequence    <= '0;
            r_time        <= '0;
            r_length      <= '0;
        end else begin
            r_in_valid <= i_in_accept;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    phd_pkg::CFG_MAGIC:       r_exp_magic   <= i_cfg_data;
                    phd_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[16:0];
                    default:                  r_exp_magic   <= r_exp_magic;
                endcase
            end
            r_count    <= n_count;
            r_magic    <= n_magic;
            r_type     <= n_type;
            r_channel  <= n_channel;
            r_sender   <= n_sender;
            r_sequence <= n_sequence;
            r_time     <= n_time;
            r_length   <= n_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_data <= i_data_in;
            r_end  <= i_packet_end;
        end
    end

    assign o_busy = r_in_valid;
    assign o_push = push;

endmodule

@@ src/phd_res_fifo.sv @@
// ----------------------------------------------------------------------------
// phd_res_fifo
// Result queue that takes up to two results per cycle and gives out one per cycle when popped.
// ----------------------------------------------------------------------------
module phd_res_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  phd_pkg::t_push              i_push,
    input  logic                        i_pop,
    output logic                        o_valid,
    output phd_pkg::t_result            o_head,
    output logic [phd_pkg::FILL_W-1:0]  o_fill
);

    phd_pkg::t_result               r_mem [phd_pkg::FIFO_DEPTH];
    logic [phd_pkg::PTR_W-1:0]      r_wr, n_wr;
    logic [phd_pkg::PTR_W-1:0]      r_rd;
    logic [phd_pkg::FILL_W-1:0]     r_fill, n_fill;
    logic [phd_pkg::PTR_W-1:0]      sum_addr;

    assign sum_addr = r_wr + phd_pkg::PTR_W'(i_push.pay_vld);

    always_comb begin
        n_wr   = r_wr + phd_pkg::PTR_W'(i_push.pay_vld) + phd_pkg::PTR_W'(i_push.sum_vld);
        n_fill = r_fill + phd_pkg::FILL_W'(i_push.pay_vld)
                 + phd_pkg::FILL_W'(i_push.sum_vld) - phd_pkg::FILL_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_fill <= n_fill;
            if (i_pop) begin
                r_rd <= r_rd + phd_pkg::PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.pay_vld) begin
            r_mem[r_wr] <= i_push.pay;
        end
        if (i_push.sum_vld) begin
            r_mem[sum_addr] <= i_push.sum;
        end
    end

    assign o_valid = (r_fill != '0);
    assign o_head  = r_mem[r_rd];
    assign o_fill  = r_fill;

endmodule

@@ src/phd_checker.sv @@
// ----------------------------------------------------------------------------
// phd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module phd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic        o_kind,
    input  logic [7:0]  o_payload_byte,
    input  logic [2:0]  o_status,
    input  logic [15:0] o_msg_type,
    input  logic [7:0]  o_channel_id,
    input  logic [31:0] o_sender_id,
    input  logic [31:0] o_sequence_num,
    input  logic [31:0] o_timestamp_bits,
    input  logic [31:0] o_payload_length,
    input  logic        o_run_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_payload_byte) && $stable(o_status))
        else $error("Stalled result transaction changed.");

    a_payload_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == phd_pkg::KIND_PAYLOAD) |->
            (o_status == phd_pkg::ST_OK) && !o_run_last && (o_payload_length == 32'd0))
        else $error("Payload transaction carries summary fields.");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == phd_pkg::KIND_SUMMARY) |->
            o_run_last && (o_payload_byte == 8'd0))
        else $error("Summary transaction is not marked last.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= phd_pkg::ST_TOO_LARGE))
        else $error("Status code out of range.");

    a_bad_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == phd_pkg::ST_SHORT) || (o_status == phd_pkg::ST_BAD_MAGIC))
            |-> (o_msg_type == 16'd0) && (o_channel_id == 8'd0) && (o_sender_id == 32'd0)
            && (o_sequence_num == 32'd0) && (o_timestamp_bits == 32'd0)
            && (o_payload_length == 32'd0))
        else $error("Rejected header reported non-zero fields.");

endmodule

bind packet_header_deframer phd_checker u_phd_checker (.*);
